FILE: hdl/sjt_pkg.sv
// Shared types, constants and helpers for the SJT permutation stepper.
// No dependencies.
package sjt_pkg;

    localparam int MAX_ELEMENTS = 8;
    localparam int POS_W        = $clog2(MAX_ELEMENTS);
    localparam int VAL_W        = 4;
    localparam int COUNT_W      = 16;
    localparam int SIZE_MIN     = 2;
    localparam int SIZE_RESET   = 8;

    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_STEP    = 2'd1,
        CMD_LOAD    = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SWAP,
        ST_EMIT,
        ST_EXHAUST
    } t_state;

    typedef struct packed {
        logic restart;
        logic load;
        logic search_start;
        logic search_step;
        logic swap;
        logic emit_next;
        logic show_exhausted;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;
        logic found;
    } t_dp_status;

    // direction of a value; values without a direction bit point left
    function automatic logic dir_of(input logic [MAX_ELEMENTS-1:0] dirs,
                                    input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] vm;
        vm = v - 1'b1;
        if (v >= VAL_W'(1) && v <= VAL_W'(MAX_ELEMENTS)) begin
            return dirs[vm[POS_W-1:0]];
        end
        return 1'b0;
    endfunction

    function automatic logic has_dir(input logic [VAL_W-1:0] v);
        return (v >= VAL_W'(1)) && (v <= VAL_W'(MAX_ELEMENTS));
    endfunction

endpackage

FILE: hdl/sjt_dp.sv
// Datapath: permutation slots, direction bits, counter, size register,
// mobile search, swap and emit. Depends on sjt_pkg.
module sjt_dp import sjt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic [POS_W-1:0]   i_position,
    input  logic [VAL_W-1:0]   i_value,
    input  logic               i_dir_right,
    input  logic               i_cfg_valid,
    input  logic [VAL_W-1:0]   i_cfg_data,
    output logic [VAL_W-1:0]   o_element_value,
    output logic [POS_W-1:0]   o_element_position,
    output logic               o_last,
    output logic               o_exhausted,
    output logic [COUNT_W-1:0] o_perm_number
);

    logic [VAL_W-1:0]        r_perm [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] r_dir;
    logic [COUNT_W-1:0]      r_count;
    logic [VAL_W-1:0]        r_size;
    logic [POS_W-1:0]        r_idx;
    logic [VAL_W-1:0]        r_best;
    logic [POS_W-1:0]        r_best_pos;
    logic                    r_best_dir;

    logic [VAL_W-1:0]        w_n;
    logic [POS_W-1:0]        w_last_idx;
    logic [MAX_ELEMENTS-1:0] w_mob;
    logic [VAL_W-1:0]        w_cur;
    logic [VAL_W-1:0]        w_cur_m1;
    logic [VAL_W-1:0]        w_val_m1;
    logic [POS_W-1:0]        w_nb_pos;

    always_comb begin
        if (r_size < VAL_W'(SIZE_MIN)) begin
            w_n = VAL_W'(SIZE_MIN);
        end else if (r_size > VAL_W'(MAX_ELEMENTS)) begin
            w_n = VAL_W'(MAX_ELEMENTS);
        end else begin
            w_n = r_size;
        end
    end
    assign w_last_idx = POS_W'(w_n - 1'b1);

    for (genvar gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_mob
        logic w_left;
        logic w_right;
        if (gi == 0) begin : g_first
            assign w_left = 1'b0;
        end else begin : g_mid_l
            assign w_left = !dir_of(r_dir, r_perm[gi]) && (r_perm[gi] > r_perm[gi-1]);
        end
        if (gi == MAX_ELEMENTS - 1) begin : g_end
            assign w_right = 1'b0;
        end else begin : g_mid_r
            assign w_right = dir_of(r_dir, r_perm[gi]) && (POS_W'(gi) != w_last_idx)
                             && (r_perm[gi] > r_perm[gi+1]);
        end
        assign w_mob[gi] = w_left | w_right;
    end

    assign w_cur    = r_perm[r_idx];
    assign w_cur_m1 = w_cur - 1'b1;
    assign w_val_m1 = i_value - 1'b1;
    assign w_nb_pos = r_best_dir ? (r_best_pos + 1'b1) : (r_best_pos - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ELEMENTS; i++) begin
                r_perm[i] <= VAL_W'(i + 1);
            end
            r_dir      <= '0;
            r_count    <= '0;
            r_size     <= VAL_W'(SIZE_RESET);
            r_idx      <= '0;
            r_best     <= '0;
            r_best_pos <= '0;
            r_best_dir <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end
            if (i_cmd.restart) begin
                for (int i = 0; i < MAX_ELEMENTS; i++) begin
                    r_perm[i] <= VAL_W'(i + 1);
                end
                r_dir   <= '0;
                r_count <= '0;
            end
            if (i_cmd.load) begin
                r_perm[i_position] <= i_value;
                if (has_dir(i_value)) begin
                    r_dir[w_val_m1[POS_W-1:0]] <= i_dir_right;
                end
            end
            if (i_cmd.search_start) begin
                r_idx  <= '0;
                r_best <= '0;
            end
            if (i_cmd.search_step) begin
                if (w_mob[r_idx] && (w_cur > r_best)) begin
                    r_best     <= w_cur;
                    r_best_pos <= r_idx;
                    r_best_dir <= dir_of(r_dir, w_cur);
                end
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.swap) begin
                r_perm[r_best_pos] <= r_perm[w_nb_pos];
                r_perm[w_nb_pos]   <= r_perm[r_best_pos];
                r_count            <= r_count + 1'b1;
                r_idx              <= '0;
            end
            if (i_cmd.emit_next) begin
                // larger values turn around as they go out
                if (has_dir(w_cur) && (w_cur > r_best)) begin
                    r_dir[w_cur_m1[POS_W-1:0]] <= ~r_dir[w_cur_m1[POS_W-1:0]];
                end
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_status.idx_last = (r_idx == w_last_idx);
    assign o_status.found    = (r_best != '0);

    assign o_element_value    = i_cmd.show_exhausted ? '0 : w_cur;
    assign o_element_position = i_cmd.show_exhausted ? '0 : r_idx;
    assign o_last             = i_cmd.show_exhausted | (r_idx == w_last_idx);
    assign o_exhausted        = i_cmd.show_exhausted;
    assign o_perm_number      = r_count;

endmodule

FILE: hdl/sjt_ctrl.sv
// Controller: issues restart and load, and sequences search, swap and emit for each step request.
// Depends on sjt_pkg.
module sjt_ctrl import sjt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    output logic       o_valid,
    input  logic       i_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_dp_cmd
);

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;
    logic   w_accept;
    logic   w_out_take;

    assign w_cmd      = t_cmd'(i_cmd);
    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign o_valid    = (r_state == ST_EMIT) || (r_state == ST_EXHAUST);
    assign w_out_take = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_RESTART: o_dp_cmd.restart = 1'b1;
                        CMD_LOAD:    o_dp_cmd.load = 1'b1;
                        CMD_STEP: begin
                            o_dp_cmd.search_start = 1'b1;
                            n_state = ST_SEARCH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEARCH: begin
                o_dp_cmd.search_step = 1'b1;
                if (i_status.idx_last) begin
                    n_state = ST_SWAP;
                end
            end
            ST_SWAP: begin
                if (i_status.found) begin
                    o_dp_cmd.swap = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_EXHAUST;
                end
            end
            ST_EMIT: begin
                if (w_out_take) begin
                    o_dp_cmd.emit_next = 1'b1;
                    if (i_status.idx_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EXHAUST: begin
                o_dp_cmd.show_exhausted = 1'b1;
                if (w_out_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: hdl/sjt_mobile_permutation_step.sv
// Step through permutations one swap of neighbors at a time, largest mobile element first.
// A restart or load request does not stall the input. A step searches the n slots, then swaps,
// then gives n results, one a cycle while the output is not stalled (n from the size
// register, clamped to 2..8). A step with no mobile element gives one exhausted result
// after the search. Input requests are stalled while a step is in progress, and the
// size register is written only between requests.
// Depends on sjt_pkg, sjt_ctrl, sjt_dp.
module sjt_mobile_permutation_step import sjt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [POS_W-1:0]   i_position,
    input  logic [VAL_W-1:0]   i_value,
    input  logic               i_dir_right,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [VAL_W-1:0]   o_element_value,
    output logic [POS_W-1:0]   o_element_position,
    output logic               o_last,
    output logic               o_exhausted,
    output logic [COUNT_W-1:0] o_perm_number,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [VAL_W-1:0]   i_cfg_data
);

    t_dp_cmd    w_dp_cmd;
    t_dp_status w_dp_status;

    assign o_cfg_ready = !o_stall;

    sjt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_dp_status),
        .o_dp_cmd (w_dp_cmd)
    );

    sjt_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_dp_cmd),
        .o_status           (w_dp_status),
        .i_position         (i_position),
        .i_value            (i_value),
        .i_dir_right        (i_dir_right),
        .i_cfg_valid        (i_cfg_valid & o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .o_element_value    (o_element_value),
        .o_element_position (o_element_position),
        .o_last             (o_last),
        .o_exhausted        (o_exhausted),
        .o_perm_number      (o_perm_number)
    );

endmodule
